@@ hdl/rc5v_pkg.sv @@
// Shared constants, types and rotate helpers for the RC5 variant block cipher.
package rc5v_pkg;

    localparam logic [31:0] MAGIC_P     = 32'hb7e15163;
    localparam logic [31:0] MAGIC_Q     = 32'h9e3779b9;
    localparam int          TABLE_WORDS = 26;
    localparam int          KEY_WORDS   = 4;
    localparam int          MIX_STEPS   = 3 * TABLE_WORDS;
    localparam int          TAB_AW      = $clog2(TABLE_WORDS);
    localparam int          CFG_AW      = $clog2(KEY_WORDS);

    // Table words used by encrypt and decrypt.
    localparam logic [TAB_AW-1:0] TK_A0 = TAB_AW'(0);
    localparam logic [TAB_AW-1:0] TK_B0 = TAB_AW'(1);
    localparam logic [TAB_AW-1:0] TK_A1 = TAB_AW'(4);
    localparam logic [TAB_AW-1:0] TK_B1 = TAB_AW'(5);

    typedef enum logic [1:0] {
        ACT_EXPAND  = 2'd0,
        ACT_ENCRYPT = 2'd1,
        ACT_DECRYPT = 2'd2
    } t_action;

    typedef enum logic [CFG_AW-1:0] {
        CFG_KEY0 = 2'd0,
        CFG_KEY1 = 2'd1,
        CFG_KEY2 = 2'd2,
        CFG_KEY3 = 2'd3
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEY_MIX,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } t_state;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] d;
        d = {v, v} >> n;
        return d[31:0];
    endfunction

endpackage

@@ hdl/rc5_variant_block_cipher.sv @@
// Top level of the RC5 variant block cipher: control, round datapath and key table.
//
// The block holds a 26-word round key table in a RAM with one read and one write port.
// A word with action 0 expands the four key registers into the table in 78 mixing
// steps, one step per cycle. Encrypt and decrypt fetch four table words over the
// single read port, then run both halves side by side at one round per cycle. An
// unused action code returns zeros. The result sits in an output register, so the
// next word is taken while a result still waits. Until the first expand the table
// reads as all zeros.
module rc5_variant_block_cipher
    import rc5v_pkg::*;
#(
    parameter int ROUNDS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_AW-1:0]    i_cfg_addr,
    input  logic [31:0]          i_cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // data_word0 [31:0], data_word1 [63:32], data_word2 [95:64], data_word3 [127:96]
    input  logic [127:0]         s_axis_tdata,
    // action [1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // out_word0 [31:0], out_word1 [63:32], out_word2 [95:64], out_word3 [127:96]
    output logic [127:0]         m_axis_tdata
);

    localparam int CNT_W = $clog2((MIX_STEPS > ROUNDS) ? MIX_STEPS : ROUNDS);

    t_state                 r_state, n_state;
    logic [31:0]            r_key [KEY_WORDS];
    logic [TABLE_WORDS-1:0] r_valid;
    logic                   r_rd_vld;
    logic [31:0]            rdata, rd_eff;
    logic                   we;
    logic [TAB_AW-1:0]      raddr;
    logic                   load_out;
    logic [CNT_W-1:0]       r_cnt;
    logic [1:0]             r_act;
    logic [TAB_AW-1:0]      r_si, si_next;
    logic [31:0]            r_a, r_b, r_init;
    logic [31:0]            r_l [KEY_WORDS];
    logic [31:0]            r_w [4];
    logic [31:0]            r_t0, r_t1, r_ka1, r_kb1;
    logic                   r_out_valid;
    logic [127:0]           r_out_data, n_out_data;
    logic [31:0]            mix_src, mix_a, mix_s, mix_b;
    logic [31:0]            rw [4];
    logic [31:0]            ka [2], kb [2];

    rc5v_ram #(.WIDTH(32), .DEPTH(TABLE_WORDS)) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_si),
        .i_wdata (mix_a),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_eff  = r_rd_vld ? rdata : 32'd0;
    assign si_next = (r_si == TAB_AW'(TABLE_WORDS - 1)) ? '0 : r_si + TAB_AW'(1);

    // One key schedule mixing step.
    assign mix_src = (r_cnt < CNT_W'(TABLE_WORDS)) ? r_init : rd_eff;
    assign mix_a   = rotl32(mix_src + r_a + r_b, 5'd3);
    assign mix_s   = mix_a + r_b;
    assign mix_b   = rotl32(r_l[r_cnt[1:0]] + mix_s, mix_s[4:0]);

    // One round on both halves.
    assign ka[0] = r_t0;
    assign kb[0] = r_t1;
    assign ka[1] = r_ka1;
    assign kb[1] = r_kb1;

    always_comb begin
        logic [31:0] a, b;
        for (int h = 0; h < 2; h++) begin
            a = r_w[2*h];
            b = r_w[2*h+1];
            if (r_act == ACT_DECRYPT) begin
                b = rotr32(b - kb[h], a[4:0]) ^ a;
                a = rotr32(a - ka[h], b[4:0]) ^ b;
            end else begin
                a = rotl32(a ^ b, b[4:0]) + ka[h];
                b = rotl32(b ^ a, a[4:0]) + kb[h];
            end
            rw[2*h]   = a;
            rw[2*h+1] = b;
        end
    end

    always_comb begin
        case (r_act)
            ACT_ENCRYPT: n_out_data = {r_w[3], r_w[2], r_w[1], r_w[0]};
            ACT_DECRYPT: n_out_data = {r_w[3] - r_t1, r_w[2] - r_t0,
                                       r_w[1] - r_t1, r_w[0] - r_t0};
            default:     n_out_data = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        we            = 1'b0;
        raddr         = TK_A0;
        load_out      = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (s_axis_tuser)
                        ACT_EXPAND:  n_state = ST_KEY_MIX;
                        ACT_ENCRYPT: n_state = ST_LOAD;
                        ACT_DECRYPT: n_state = ST_LOAD;
                        default:     n_state = ST_DONE;
                    endcase
                end
            end
            ST_KEY_MIX: begin
                we    = 1'b1;
                raddr = si_next;
                if (r_cnt == CNT_W'(MIX_STEPS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_LOAD: begin
                unique case (r_cnt[1:0])
                    2'd0: raddr = TK_A0;
                    2'd1: raddr = TK_B0;
                    2'd2: raddr = TK_A1;
                    2'd3: raddr = TK_B1;
                endcase
                if (r_cnt == CNT_W'(4)) begin
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                if (r_cnt == CNT_W'(ROUNDS - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
        endcase
    end

    // Control registers: key words, table valid bits, output handshake.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEY_WORDS; i++) begin
                r_key[i] <= '0;
            end
            r_valid     <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_key[i_cfg_addr] <= i_cfg_data;
            end
            if (we) begin
                r_valid[r_si] <= 1'b1;
            end
            r_rd_vld <= r_valid[raddr];
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= n_out_data;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_cnt  <= '0;
                r_si   <= '0;
                r_a    <= '0;
                r_b    <= '0;
                r_init <= MAGIC_P;
                r_act  <= s_axis_tuser;
                for (int i = 0; i < 4; i++) begin
                    r_w[i] <= s_axis_tdata[32*i +: 32];
                end
                for (int i = 0; i < KEY_WORDS; i++) begin
                    r_l[i] <= r_key[i];
                end
            end
            ST_KEY_MIX: begin
                r_a            <= mix_a;
                r_b            <= mix_b;
                r_l[r_cnt[1:0]] <= mix_b;
                r_init         <= r_init + MAGIC_Q;
                r_si           <= si_next;
                r_cnt          <= r_cnt + CNT_W'(1);
            end
            ST_LOAD: begin
                r_cnt <= r_cnt + CNT_W'(1);
                case (r_cnt[2:0])
                    3'd1: r_t0  <= rd_eff;
                    3'd2: r_t1  <= rd_eff;
                    3'd3: r_ka1 <= rd_eff;
                    3'd4: begin
                        r_kb1 <= rd_eff;
                        r_cnt <= '0;
                        if (r_act == ACT_ENCRYPT) begin
                            r_w[0] <= r_w[0] + r_t0;
                            r_w[1] <= r_w[1] + r_t1;
                            r_w[2] <= r_w[2] + r_t0;
                            r_w[3] <= r_w[3] + r_t1;
                        end
                    end
                    default: ;
                endcase
            end
            ST_ROUND: begin
                r_cnt <= r_cnt + CNT_W'(1);
                for (int i = 0; i < 4; i++) begin
                    r_w[i] <= rw[i];
                end
            end
            ST_DONE: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ hdl/rc5v_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module rc5v_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 26
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/rc5v_checker.sv @@
// Port-level checker for the RC5 variant block cipher and its bind statement.
module rc5v_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result word changed while stalled");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // The core is busy in the cycle after it takes a word.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after an accepted word");

    // A new result only appears while the core was busy.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without work in progress");

endmodule

bind rc5_variant_block_cipher rc5v_checker u_rc5v_checker (.*);

@@ bench/testbench.sv @@
// Self-checking testbench for the RC5 variant block cipher with a cycle-free predictor.
module testbench
    import rc5v_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CIPHER_ROUNDS = 12;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          TAIL_CYCLES   = 120;
    localparam logic [1:0]  ACT_UNUSED    = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_AW-1:0]    i_cfg_addr;
    logic [31:0]          i_cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [127:0]         s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [127:0]         m_axis_tdata;

    logic [31:0]  key_reg [KEY_WORDS];
    logic [31:0]  key_table [TABLE_WORDS];
    logic [127:0] expected_blocks [$];
    int           mismatch_count;
    int           idle_cycles;
    int           burst_left;
    int           stall_mode;
    int           stall_left;

    rc5_variant_block_cipher #(
        .ROUNDS(CIPHER_ROUNDS)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] v, input logic [4:0] n);
        if (n == 5'd0) begin
            return v;
        end
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] rot_right(input logic [31:0] v, input logic [4:0] n);
        if (n == 5'd0) begin
            return v;
        end
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void expand_key_table();
        logic [31:0] mix_key [KEY_WORDS];
        logic [31:0] a;
        logic [31:0] b;
        int          si;
        int          li;
        for (int k = 0; k < KEY_WORDS; k++) begin
            mix_key[k] = key_reg[k];
        end
        key_table[0] = MAGIC_P;
        for (int k = 1; k < TABLE_WORDS; k++) begin
            key_table[k] = key_table[k-1] + MAGIC_Q;
        end
        a  = '0;
        b  = '0;
        si = 0;
        li = 0;
        for (int step = 0; step < MIX_STEPS; step++) begin
            a = rot_left(key_table[si] + a + b, 5'd3);
            key_table[si] = a;
            b = rot_left(mix_key[li] + a + b, 5'(a + b));
            mix_key[li] = b;
            si = (si + 1) % TABLE_WORDS;
            li = (li + 1) % KEY_WORDS;
        end
    endfunction

    function automatic logic [63:0] encrypt_half(input logic [63:0] hw, input int half);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ka;
        logic [31:0] kb;
        a  = hw[31:0] + key_table[0];
        b  = hw[63:32] + key_table[1];
        ka = key_table[4*half];
        kb = key_table[4*half+1];
        repeat (CIPHER_ROUNDS) begin
            a = rot_left(a ^ b, b[4:0]) + ka;
            b = rot_left(b ^ a, a[4:0]) + kb;
        end
        return {b, a};
    endfunction

    function automatic logic [63:0] decrypt_half(input logic [63:0] hw, input int half);
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] ka;
        logic [31:0] kb;
        a  = hw[31:0];
        b  = hw[63:32];
        ka = key_table[4*half];
        kb = key_table[4*half+1];
        repeat (CIPHER_ROUNDS) begin
            b = rot_right(b - kb, a[4:0]) ^ a;
            a = rot_right(a - ka, b[4:0]) ^ b;
        end
        return {b - key_table[1], a - key_table[0]};
    endfunction

    function automatic logic [127:0] predict_block(input logic [1:0] act,
                                                   input logic [127:0] d);
        case (act)
            ACT_ENCRYPT: begin
                return {encrypt_half(d[127:64], 1), encrypt_half(d[63:0], 0)};
            end
            ACT_DECRYPT: begin
                return {decrypt_half(d[127:64], 1), decrypt_half(d[63:0], 0)};
            end
            ACT_EXPAND: begin
                expand_key_table();
                return '0;
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    // Checks results against the oldest prediction, then records newly accepted words.
    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("Unexpected result word %h at %0t", m_axis_tdata, $realtime);
                end
            end else begin
                want = expected_blocks.pop_front();
                for (int k = 0; k < 4; k++) begin
                    if (m_axis_tdata[k*32 +: 32] !== want[k*32 +: 32]) begin
                        mismatch_count++;
                        if (mismatch_count <= 10) begin
                            $display("out_word%0d mismatch at %0t: expected %h, got %h",
                                     k, $realtime, want[k*32 +: 32], m_axis_tdata[k*32 +: 32]);
                        end
                    end
                end
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            expected_blocks.push_back(predict_block(s_axis_tuser, s_axis_tdata));
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // The receiver switches between always ready, coin-flip and mostly stalled stretches.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_block(input logic [1:0] act, input logic [127:0] d);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 25);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_blocks.size() != 0);
    endtask

    task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                            input logic [31:0] k2, input logic [31:0] k3);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_KEY0;
        i_cfg_data <= k0;
        key_reg[CFG_KEY0] = k0;
        @(negedge i_clk);
        i_cfg_addr <= CFG_KEY1;
        i_cfg_data <= k1;
        key_reg[CFG_KEY1] = k1;
        @(negedge i_clk);
        i_cfg_addr <= CFG_KEY2;
        i_cfg_data <= k2;
        key_reg[CFG_KEY2] = k2;
        @(negedge i_clk);
        i_cfg_addr <= CFG_KEY3;
        i_cfg_data <= k3;
        key_reg[CFG_KEY3] = k3;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Before any expansion the table is all zeros, which also yields rotates by zero.
    task automatic test_reset_table();
        send_block(ACT_ENCRYPT, '0);
        send_block(ACT_ENCRYPT, '1);
        send_block(ACT_DECRYPT, '0);
        send_block(ACT_DECRYPT, '1);
        send_block(ACT_ENCRYPT, {4{32'h0000_0020}});
    endtask

    task automatic test_unused_action();
        send_block(ACT_UNUSED, {$urandom, $urandom, $urandom, $urandom});
        send_block(ACT_UNUSED, '1);
        send_block(ACT_ENCRYPT, {$urandom, $urandom, $urandom, $urandom});
    endtask

    task automatic test_key_expansion();
        send_block(ACT_EXPAND, {$urandom, $urandom, $urandom, $urandom});
        send_block(ACT_ENCRYPT, '0);
        send_block(ACT_DECRYPT, '1);
        load_key('1, '1, '1, '1);
        send_block(ACT_EXPAND, '0);
        send_block(ACT_EXPAND, '1);
        send_block(ACT_ENCRYPT, '0);
        send_block(ACT_ENCRYPT, '1);
        send_block(ACT_DECRYPT, '0);
        send_block(ACT_DECRYPT, '1);
        load_key(32'haaaa_aaaa, 32'h5555_5555, 32'h0000_0000, 32'hffff_ffff);
        send_block(ACT_EXPAND, '0);
        send_block(ACT_ENCRYPT, {$urandom, $urandom, $urandom, $urandom});
        send_block(ACT_DECRYPT, {$urandom, $urandom, $urandom, $urandom});
    endtask

    task automatic test_random_traffic(input int count);
        logic [127:0] d;
        logic [1:0]   act;
        int           pick;
        for (int n = 0; n < count; n++) begin
            if (n % 200 == 100) begin
                case ($urandom_range(0, 3))
                    0:       load_key('0, '0, '0, '0);
                    1:       load_key('1, '1, '1, '1);
                    2:       load_key('1, '0, '1, '0);
                    default: load_key($urandom, $urandom, $urandom, $urandom);
                endcase
                send_block(ACT_EXPAND, {$urandom, $urandom, $urandom, $urandom});
            end
            if (n == count / 2) begin
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 46) begin
                act = ACT_ENCRYPT;
            end else if (pick < 92) begin
                act = ACT_DECRYPT;
            end else if (pick < 97) begin
                act = ACT_EXPAND;
            end else begin
                act = ACT_UNUSED;
            end
            for (int k = 0; k < 4; k++) begin
                case ($urandom_range(0, 15))
                    0:       d[k*32 +: 32] = '0;
                    1:       d[k*32 +: 32] = '1;
                    2:       d[k*32 +: 32] = {27'($urandom), 5'd0};
                    default: d[k*32 +: 32] = $urandom;
                endcase
            end
            send_block(act, d);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = CFG_KEY0;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_EXPAND;
        m_axis_tready  = 1'b0;
        mismatch_count = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        stall_mode     = 0;
        stall_left     = 0;
        for (int k = 0; k < KEY_WORDS; k++) begin
            key_reg[k] = '0;
        end
        for (int k = 0; k < TABLE_WORDS; k++) begin
            key_table[k] = '0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_table();
        test_unused_action();
        test_key_expansion();
        test_random_traffic(1030);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_blocks.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/rc5v_pkg.sv
hdl/rc5v_ram.sv
hdl/rc5_variant_block_cipher.sv
hdl/rc5v_checker.sv
bench/testbench.sv
